[sv/lnc_pkg.sv]
// Shared constants for the lattice neighbour cell step block.
package lnc_pkg;

   localparam int INDEX_WIDTH_DEF = 16;
   localparam int POS_WIDTH_DEF   = 32;

   localparam int CELLS_WIDTH    = 8;
   localparam int PITCH_WIDTH    = 31;
   localparam int FILL_WIDTH     = 16;
   localparam int SURF_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int REG_SEL_WIDTH  = 3;

   // Register map, word index into the CSR space
   localparam logic [REG_SEL_WIDTH-1:0] REG_LATTICE_KIND   = 3'd0;
   localparam logic [REG_SEL_WIDTH-1:0] REG_CELLS_X        = 3'd1;
   localparam logic [REG_SEL_WIDTH-1:0] REG_CELLS_Y        = 3'd2;
   localparam logic [REG_SEL_WIDTH-1:0] REG_PITCH_X        = 3'd3;
   localparam logic [REG_SEL_WIDTH-1:0] REG_PITCH_Y        = 3'd4;
   localparam logic [REG_SEL_WIDTH-1:0] REG_PITCH_Z        = 3'd5;
   localparam logic [REG_SEL_WIDTH-1:0] REG_HEX_ROW_HEIGHT = 3'd6;
   localparam logic [REG_SEL_WIDTH-1:0] REG_FILLED_CELLS   = 3'd7;

   localparam logic KIND_RECT = 1'b1;
   localparam logic KIND_HEX  = 1'b0;

   // Crossed surface codes
   localparam logic [SURF_WIDTH-1:0] SURF_S1 = 3'd1;
   localparam logic [SURF_WIDTH-1:0] SURF_S2 = 3'd2;
   localparam logic [SURF_WIDTH-1:0] SURF_S3 = 3'd3;
   localparam logic [SURF_WIDTH-1:0] SURF_S4 = 3'd4;
   localparam logic [SURF_WIDTH-1:0] SURF_S5 = 3'd5;
   localparam logic [SURF_WIDTH-1:0] SURF_S6 = 3'd6;

   // Reset values
   localparam logic                   RESET_KIND   = KIND_RECT;
   localparam logic [CELLS_WIDTH-1:0] RESET_CELLS  = 8'd1;
   localparam logic [PITCH_WIDTH-1:0] RESET_PITCH  = 31'd65536;
   localparam logic [FILL_WIDTH-1:0]  RESET_FILLED = 16'd0;

endpackage

[sv/lnc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with sideband payload.
module lnc_div import lnc_pkg::*; #(
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEF,
   parameter int SIDE_WIDTH  = 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   in_valid,
   input  logic [INDEX_WIDTH-1:0] in_dividend,
   input  logic [CELLS_WIDTH-1:0] in_divisor,
   input  logic [SIDE_WIDTH-1:0]  in_side,
   output logic                   out_valid,
   output logic [INDEX_WIDTH-1:0] out_quotient,
   output logic [CELLS_WIDTH-1:0] out_remainder,
   output logic [SIDE_WIDTH-1:0]  out_side
);

   logic                   valid_ff [INDEX_WIDTH];
   logic [INDEX_WIDTH-1:0] num_ff   [INDEX_WIDTH];
   logic [INDEX_WIDTH-1:0] quo_ff   [INDEX_WIDTH];
   logic [CELLS_WIDTH-1:0] rem_ff   [INDEX_WIDTH];
   logic [CELLS_WIDTH-1:0] div_ff   [INDEX_WIDTH];
   logic [SIDE_WIDTH-1:0]  side_ff  [INDEX_WIDTH];

   logic                   valid_in [INDEX_WIDTH];
   logic [INDEX_WIDTH-1:0] num_in   [INDEX_WIDTH];
   logic [INDEX_WIDTH-1:0] quo_in   [INDEX_WIDTH];
   logic [CELLS_WIDTH-1:0] rem_in   [INDEX_WIDTH];
   logic [CELLS_WIDTH-1:0] div_in   [INDEX_WIDTH];
   logic [SIDE_WIDTH-1:0]  side_in  [INDEX_WIDTH];

   genvar s;
   generate
      for (s = 0; s < INDEX_WIDTH; s++) begin : g_stage
         logic                   src_valid;
         logic [INDEX_WIDTH-1:0] src_num;
         logic [INDEX_WIDTH-1:0] src_quo;
         logic [CELLS_WIDTH-1:0] src_rem;
         logic [CELLS_WIDTH-1:0] src_div;
         logic [SIDE_WIDTH-1:0]  src_side;
         logic [CELLS_WIDTH:0]   trial;
         logic                   qbit;

         if (s == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_num   = in_dividend;
            assign src_quo   = '0;
            assign src_rem   = '0;
            assign src_div   = in_divisor;
            assign src_side  = in_side;
         end else begin : g_next
            assign src_valid = valid_ff[s-1];
            assign src_num   = num_ff[s-1];
            assign src_quo   = quo_ff[s-1];
            assign src_rem   = rem_ff[s-1];
            assign src_div   = div_ff[s-1];
            assign src_side  = side_ff[s-1];
         end

         // shift in next dividend bit, subtract divisor if it fits
         always_comb begin
            trial = {src_rem, src_num[INDEX_WIDTH-1]};
            qbit  = (trial >= {1'b0, src_div});
            valid_in[s] = src_valid;
            num_in[s]   = {src_num[INDEX_WIDTH-2:0], 1'b0};
            quo_in[s]   = {src_quo[INDEX_WIDTH-2:0], qbit};
            rem_in[s]   = qbit ? CELLS_WIDTH'(trial - {1'b0, src_div})
                               : trial[CELLS_WIDTH-1:0];
            div_in[s]   = src_div;
            side_in[s]  = src_side;
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[s] <= 1'b0;
            end else if (enable) begin
               valid_ff[s] <= valid_in[s];
            end
            if (enable) begin
               num_ff[s]  <= num_in[s];
               quo_ff[s]  <= quo_in[s];
               rem_ff[s]  <= rem_in[s];
               div_ff[s]  <= div_in[s];
               side_ff[s] <= side_in[s];
            end
         end
      end
   endgenerate

   assign out_valid     = valid_ff[INDEX_WIDTH-1];
   assign out_quotient  = quo_ff[INDEX_WIDTH-1];
   assign out_remainder = rem_ff[INDEX_WIDTH-1];
   assign out_side      = side_ff[INDEX_WIDTH-1];

endmodule

[sv/lattice_neighbor_cell_step.sv]
// Lattice neighbour cell step: top level with CSRs, position and index pipeline.
//
// Takes one boundary-crossing event per transfer (1-based cell index, crossed surface 1..6,
// signed Q16.16 position) and returns the neighbouring cell index, a valid flag and the
// position moved into the neighbour's local frame. Rectangular lattices step the index by
// 1, nx or nx*ny; hexagonal lattices split index-1 into column and row by dividing by nx,
// step them and bounds-check. Position adds saturate. One item is taken every clock; the
// whole pipeline holds while the result register is stalled. Each item passes through the
// input register, stage B, the pipelined column/row divider that retires one quotient bit
// per stage, stages D and E and the result register. Configuration registers sit on an
// APB-style port at byte address 4*i and must only be written while no item is in flight.
module lattice_neighbor_cell_step import lnc_pkg::*; #(
   parameter int INDEX_WIDTH = INDEX_WIDTH_DEF,
   parameter int POS_WIDTH   = POS_WIDTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [INDEX_WIDTH-1:0]      req_cell_index,
   input  logic [SURF_WIDTH-1:0]       req_surface,
   input  logic signed [POS_WIDTH-1:0] req_pos_x,
   input  logic signed [POS_WIDTH-1:0] req_pos_y,
   input  logic signed [POS_WIDTH-1:0] req_pos_z,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [INDEX_WIDTH-1:0]      rsp_next_index,
   output logic                        rsp_index_valid,
   output logic signed [POS_WIDTH-1:0] rsp_new_x,
   output logic signed [POS_WIDTH-1:0] rsp_new_y,
   output logic signed [POS_WIDTH-1:0] rsp_new_z,
   // configuration port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]   paddr,
   input  logic [CSR_DATA_WIDTH-1:0]   pwdata,
   output logic [CSR_DATA_WIDTH-1:0]   prdata,
   output logic                        pready
);

   // Adder width: room for the position or a 31-bit pitch plus sign and carry
   localparam int SW  = ((POS_WIDTH > PITCH_WIDTH) ? POS_WIDTH : PITCH_WIDTH) + 2;
   // Candidate index width: index plus nx*ny, signed
   localparam int NW  = ((INDEX_WIDTH > 2*CELLS_WIDTH+1) ? INDEX_WIDTH : 2*CELLS_WIDTH+1) + 2;
   localparam int I1W = CELLS_WIDTH + 2;
   localparam int I2W = INDEX_WIDTH + 2;
   localparam int HW  = 2*CELLS_WIDTH + 1;

   localparam logic signed [SW-1:0] SAT_MAX = {{(SW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_MIN = {{(SW-POS_WIDTH+1){1'b1}}, {(POS_WIDTH-1){1'b0}}};
   localparam logic signed [NW-1:0] IDX_MAX = {{(NW-INDEX_WIDTH){1'b0}}, {INDEX_WIDTH{1'b1}}};

   typedef struct packed {
      logic                  rect;
      logic [SURF_WIDTH-1:0] surf;
      logic                  pre_ok;
      logic [NW-1:0]         rect_nidx;
      logic [POS_WIDTH-1:0]  x;
      logic [POS_WIDTH-1:0]  y;
      logic [POS_WIDTH-1:0]  z;
   } side_type;

   localparam int SIDE_WIDTH = $bits(side_type);

   function automatic logic [POS_WIDTH-1:0] sat_add(input logic [POS_WIDTH-1:0] a,
                                                    input logic signed [SW-1:0] d);
      logic signed [SW-1:0] sum;
      sum = $signed({{(SW-POS_WIDTH){a[POS_WIDTH-1]}}, a}) + d;
      if (sum > SAT_MAX) begin
         return SAT_MAX[POS_WIDTH-1:0];
      end else if (sum < SAT_MIN) begin
         return SAT_MIN[POS_WIDTH-1:0];
      end
      return sum[POS_WIDTH-1:0];
   endfunction

   function automatic logic signed [SW-1:0] plus(input logic [PITCH_WIDTH-1:0] p);
      return $signed({{(SW-PITCH_WIDTH){1'b0}}, p});
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic                     kind_ff;
   logic [CELLS_WIDTH-1:0]   cells_x_ff;
   logic [CELLS_WIDTH-1:0]   cells_y_ff;
   logic [PITCH_WIDTH-1:0]   pitch_x_ff;
   logic [PITCH_WIDTH-1:0]   pitch_y_ff;
   logic [PITCH_WIDTH-1:0]   pitch_z_ff;
   logic [PITCH_WIDTH-1:0]   row_height_ff;
   logic [FILL_WIDTH-1:0]    filled_ff;
   logic [2*CELLS_WIDTH-1:0] nxny_ff;
   logic [REG_SEL_WIDTH-1:0] reg_sel;
   logic                     csr_write;

   assign pready    = 1'b1;
   assign reg_sel   = paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff       <= RESET_KIND;
         cells_x_ff    <= RESET_CELLS;
         cells_y_ff    <= RESET_CELLS;
         pitch_x_ff    <= RESET_PITCH;
         pitch_y_ff    <= RESET_PITCH;
         pitch_z_ff    <= RESET_PITCH;
         row_height_ff <= RESET_PITCH;
         filled_ff     <= RESET_FILLED;
      end else if (csr_write) begin
         case (reg_sel)
            REG_LATTICE_KIND:   kind_ff       <= pwdata[0];
            REG_CELLS_X:        cells_x_ff    <= pwdata[CELLS_WIDTH-1:0];
            REG_CELLS_Y:        cells_y_ff    <= pwdata[CELLS_WIDTH-1:0];
            REG_PITCH_X:        pitch_x_ff    <= pwdata[PITCH_WIDTH-1:0];
            REG_PITCH_Y:        pitch_y_ff    <= pwdata[PITCH_WIDTH-1:0];
            REG_PITCH_Z:        pitch_z_ff    <= pwdata[PITCH_WIDTH-1:0];
            REG_HEX_ROW_HEIGHT: row_height_ff <= pwdata[PITCH_WIDTH-1:0];
            REG_FILLED_CELLS:   filled_ff     <= pwdata[FILL_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // registered plane size; the user keeps config quiet while items fly (not enforced)
   always_ff @(posedge clock) begin
      nxny_ff <= cells_x_ff * cells_y_ff;
   end

   always_comb begin
      case (reg_sel)
         REG_LATTICE_KIND:   prdata = CSR_DATA_WIDTH'(kind_ff);
         REG_CELLS_X:        prdata = CSR_DATA_WIDTH'(cells_x_ff);
         REG_CELLS_Y:        prdata = CSR_DATA_WIDTH'(cells_y_ff);
         REG_PITCH_X:        prdata = CSR_DATA_WIDTH'(pitch_x_ff);
         REG_PITCH_Y:        prdata = CSR_DATA_WIDTH'(pitch_y_ff);
         REG_PITCH_Z:        prdata = CSR_DATA_WIDTH'(pitch_z_ff);
         REG_HEX_ROW_HEIGHT: prdata = CSR_DATA_WIDTH'(row_height_ff);
         REG_FILLED_CELLS:   prdata = CSR_DATA_WIDTH'(filled_ff);
         default:            prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline control: everything advances unless the result is held
   // ------------------------------------------------------------------
   logic enable;
   logic rsp_valid_ff;

   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   // ------------------------------------------------------------------
   // Stage A: input register
   // ------------------------------------------------------------------
   logic                   a_valid_ff;
   logic [INDEX_WIDTH-1:0] a_idx_ff;
   logic [SURF_WIDTH-1:0]  a_surf_ff;
   logic [POS_WIDTH-1:0]   a_x_ff;
   logic [POS_WIDTH-1:0]   a_y_ff;
   logic [POS_WIDTH-1:0]   a_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (enable) begin
         a_valid_ff <= req_valid;
      end
      if (enable) begin
         a_idx_ff  <= req_cell_index;
         a_surf_ff <= req_surface;
         a_x_ff    <= req_pos_x;
         a_y_ff    <= req_pos_y;
         a_z_ff    <= req_pos_z;
      end
   end

   // ------------------------------------------------------------------
   // A -> B: position shift with saturation, rectangular step, divider operand
   // ------------------------------------------------------------------
   logic signed [SW-1:0]   dx, dy, dz;
   logic [NW-1:0]          step;
   logic                   step_down;
   logic                   surf_ok;
   logic [PITCH_WIDTH-1:0] half_px;
   logic [NW-1:0]          idx_ext;
   side_type               b_side_in;
   logic [INDEX_WIDTH-1:0] b_dividend_in;

   assign half_px = {1'b0, pitch_x_ff[PITCH_WIDTH-1:1]};
   assign idx_ext = {{(NW-INDEX_WIDTH){1'b0}}, a_idx_ff};

   always_comb begin
      dx        = '0;
      dy        = '0;
      dz        = '0;
      step      = '0;
      step_down = 1'b0;
      surf_ok   = 1'b1;
      if (kind_ff == KIND_RECT) begin
         case (a_surf_ff)
            SURF_S1: begin
               step = {{(NW-1){1'b0}}, 1'b1}; step_down = 1'b1; dx = plus(pitch_x_ff);
            end
            SURF_S2: begin
               step = {{(NW-1){1'b0}}, 1'b1}; dx = -plus(pitch_x_ff);
            end
            SURF_S3: begin
               step = {{(NW-CELLS_WIDTH){1'b0}}, cells_x_ff}; step_down = 1'b1;
               dy = plus(pitch_y_ff);
            end
            SURF_S4: begin
               step = {{(NW-CELLS_WIDTH){1'b0}}, cells_x_ff}; dy = -plus(pitch_y_ff);
            end
            SURF_S5: begin
               step = {{(NW-2*CELLS_WIDTH){1'b0}}, nxny_ff}; step_down = 1'b1;
               dz = plus(pitch_z_ff);
            end
            SURF_S6: begin
               step = {{(NW-2*CELLS_WIDTH){1'b0}}, nxny_ff}; dz = -plus(pitch_z_ff);
            end
            default: surf_ok = 1'b0;
         endcase
      end else begin
         case (a_surf_ff)
            SURF_S1: dx = plus(pitch_x_ff);
            SURF_S2: begin dx = plus(half_px);  dy = plus(row_height_ff);  end
            SURF_S3: begin dx = -plus(half_px); dy = plus(row_height_ff);  end
            SURF_S4: dx = -plus(pitch_x_ff);
            SURF_S5: begin dx = -plus(half_px); dy = -plus(row_height_ff); end
            SURF_S6: begin dx = plus(half_px);  dy = -plus(row_height_ff); end
            default: surf_ok = 1'b0;
         endcase
      end

      b_side_in.rect      = (kind_ff == KIND_RECT);
      b_side_in.surf      = a_surf_ff;
      // hex needs a non-zero index and column count to split into column/row
      b_side_in.pre_ok    = (kind_ff == KIND_RECT) ? surf_ok
                          : (surf_ok && (a_idx_ff != '0) && (cells_x_ff != '0));
      b_side_in.rect_nidx = step_down ? (idx_ext - step) : (idx_ext + step);
      b_side_in.x         = sat_add(a_x_ff, dx);
      b_side_in.y         = sat_add(a_y_ff, dy);
      b_side_in.z         = sat_add(a_z_ff, dz);
      b_dividend_in       = a_idx_ff - {{(INDEX_WIDTH-1){1'b0}}, 1'b1};
   end

   logic                   b_valid_ff;
   side_type               b_side_ff;
   logic [INDEX_WIDTH-1:0] b_dividend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (enable) begin
         b_valid_ff <= a_valid_ff;
      end
      if (enable) begin
         b_side_ff     <= b_side_in;
         b_dividend_ff <= b_dividend_in;
      end
   end

   // ------------------------------------------------------------------
   // Column/row split: (index-1) / nx, one quotient bit per stage
   // ------------------------------------------------------------------
   logic                   c_valid;
   logic [INDEX_WIDTH-1:0] c_row;
   logic [CELLS_WIDTH-1:0] c_col;
   logic [SIDE_WIDTH-1:0]  c_side_bits;
   side_type               c_side;

   lnc_div #(
      .INDEX_WIDTH (INDEX_WIDTH),
      .SIDE_WIDTH  (SIDE_WIDTH)
   ) u_div (
      .clock         (clock),
      .reset         (reset),
      .enable        (enable),
      .in_valid      (b_valid_ff),
      .in_dividend   (b_dividend_ff),
      .in_divisor    (cells_x_ff),
      .in_side       (b_side_ff),
      .out_valid     (c_valid),
      .out_quotient  (c_row),
      .out_remainder (c_col),
      .out_side      (c_side_bits)
   );

   assign c_side = side_type'(c_side_bits);

   // ------------------------------------------------------------------
   // C -> D: hex column/row step and bounds check
   // ------------------------------------------------------------------
   logic signed [I1W-1:0] d1, i1s;
   logic signed [I2W-1:0] d2, i2s;
   logic                  in_bounds;

   always_comb begin
      d1 = '0;
      d2 = '0;
      case (c_side.surf)
         SURF_S1: d1 = -I1W'(1);
         SURF_S2: d2 = -I2W'(1);
         SURF_S3: begin d1 = I1W'(1);  d2 = -I2W'(1); end
         SURF_S4: d1 = I1W'(1);
         SURF_S5: d2 = I2W'(1);
         SURF_S6: begin d1 = -I1W'(1); d2 = I2W'(1);  end
         default: ;
      endcase
      i1s = $signed({2'b00, c_col}) + d1;
      i2s = $signed({2'b00, c_row}) + d2;
      in_bounds = !i1s[I1W-1] && (i1s < $signed({2'b00, cells_x_ff}))
               && !i2s[I2W-1] && (i2s < $signed({{(I2W-CELLS_WIDTH){1'b0}}, cells_y_ff}));
   end

   logic                   d_valid_ff;
   side_type               d_side_ff;
   logic                   d_hex_ok_ff;
   logic [CELLS_WIDTH-1:0] d_i1_ff;
   logic [CELLS_WIDTH-1:0] d_i2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (enable) begin
         d_valid_ff <= c_valid;
      end
      if (enable) begin
         d_side_ff   <= c_side;
         d_hex_ok_ff <= c_side.pre_ok && in_bounds;
         // in bounds both fit the cell-count width
         d_i1_ff     <= i1s[CELLS_WIDTH-1:0];
         d_i2_ff     <= i2s[CELLS_WIDTH-1:0];
      end
   end

   // ------------------------------------------------------------------
   // D -> E: hex index rebuild, choose candidate by lattice kind
   // ------------------------------------------------------------------
   logic [2*CELLS_WIDTH-1:0] hex_prod;
   logic [HW-1:0]            hex_nidx;
   logic [NW-1:0]            cand;
   logic                     cand_ok;

   always_comb begin
      hex_prod = cells_x_ff * d_i2_ff;
      hex_nidx = {1'b0, hex_prod} + {{(HW-CELLS_WIDTH){1'b0}}, d_i1_ff}
               + {{(HW-1){1'b0}}, 1'b1};
      cand     = d_side_ff.rect ? d_side_ff.rect_nidx : {{(NW-HW){1'b0}}, hex_nidx};
      cand_ok  = d_side_ff.rect ? d_side_ff.pre_ok : d_hex_ok_ff;
   end

   logic                 e_valid_ff;
   logic [NW-1:0]        e_cand_ff;
   logic                 e_ok_ff;
   logic [POS_WIDTH-1:0] e_x_ff;
   logic [POS_WIDTH-1:0] e_y_ff;
   logic [POS_WIDTH-1:0] e_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (enable) begin
         e_valid_ff <= d_valid_ff;
      end
      if (enable) begin
         e_cand_ff <= cand;
         e_ok_ff   <= cand_ok;
         e_x_ff    <= d_side_ff.x;
         e_y_ff    <= d_side_ff.y;
         e_z_ff    <= d_side_ff.z;
      end
   end

   // ------------------------------------------------------------------
   // E -> result register: range check against 1..filled and index width
   // ------------------------------------------------------------------
   logic                   final_ok;
   logic [INDEX_WIDTH-1:0] rsp_index_ff;
   logic                   rsp_ok_ff;
   logic [POS_WIDTH-1:0]   rsp_x_ff;
   logic [POS_WIDTH-1:0]   rsp_y_ff;
   logic [POS_WIDTH-1:0]   rsp_z_ff;

   assign final_ok = e_ok_ff
                  && ($signed(e_cand_ff) > $signed({NW{1'b0}}))
                  && ($signed(e_cand_ff) <= $signed({{(NW-FILL_WIDTH){1'b0}}, filled_ff}))
                  && ($signed(e_cand_ff) <= IDX_MAX);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= e_valid_ff;
      end
      if (enable) begin
         rsp_index_ff <= final_ok ? e_cand_ff[INDEX_WIDTH-1:0] : '0;
         rsp_ok_ff    <= final_ok;
         rsp_x_ff     <= e_x_ff;
         rsp_y_ff     <= e_y_ff;
         rsp_z_ff     <= e_z_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_next_index  = rsp_index_ff;
   assign rsp_index_valid = rsp_ok_ff;
   assign rsp_new_x       = rsp_x_ff;
   assign rsp_new_y       = rsp_y_ff;
   assign rsp_new_z       = rsp_z_ff;

`ifndef SYNTHESIS
   // an invalid neighbour always reports index zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_index_valid) |-> (rsp_next_index == '0))
      else $error("invalid neighbour with non-zero index");

   // a valid neighbour lies in 1..filled_cells
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_index_valid) |->
         ((rsp_next_index != '0) &&
          ({{(NW-INDEX_WIDTH){1'b0}}, rsp_next_index} <= {{(NW-FILL_WIDTH){1'b0}}, filled_ff})))
      else $error("valid neighbour outside filled range");

   // a held result keeps its x position and index while stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_new_x) && $stable(rsp_next_index)))
      else $error("stalled result changed");
`endif

endmodule
